[sv/ssbm_pkg.sv]
// Package: widths, codes, config struct and divide helpers for the stripe mapper.
package ssbm_pkg;

    localparam int NUM_DEVICES  = 4;
    localparam int PAGE_SHIFT   = 12;
    localparam int SECTOR_SHIFT = 3;

    localparam int BLOCK_W   = 30;
    localparam int BYTES_W   = 24;
    localparam int PAGES_W   = BYTES_W + 1 - PAGE_SHIFT;
    localparam int SHIFT_W   = 5;
    localparam int DEVPG_W   = 28;
    localparam int PRESENT_W = 4;
    localparam int DEV_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int SECTOR_W  = 33;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 28;
    localparam int DEV_SLOTS = 4;

    localparam bit NDEV_POW2 = ((NUM_DEVICES & (NUM_DEVICES - 1)) == 0);
    localparam int NDEV_LOG2 = $clog2(NUM_DEVICES);
    localparam longint unsigned NDEV_RECIP_L =
        ((64'd1 << 32) + 64'(NUM_DEVICES) - 64'd1) / 64'(NUM_DEVICES);
    localparam logic [33:0] NDEV_RECIP = NDEV_RECIP_L[33:0];

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_CROSS  = 2'd1,
        STAT_END    = 2'd2,
        STAT_ABSENT = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRIPE_SHIFT   = 3'd0,
        REG_DEV0_PAGES     = 3'd1,
        REG_DEV1_PAGES     = 3'd2,
        REG_DEV2_PAGES     = 3'd3,
        REG_DEV3_PAGES     = 3'd4,
        REG_DEVICE_PRESENT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SHIFT_W-1:0]                  stripe_shift;
        logic [DEV_SLOTS-1:0][DEVPG_W-1:0]   dev_pages;
        logic [PRESENT_W-1:0]                device_present;
    } cfg_t;

    typedef struct packed {
        status_t                status;
        logic [DEV_W-1:0]       device_index;
        logic [SECTOR_W-1:0]    device_sector;
    } result_t;

    // Quotient by the device count: shift for powers of two, else reciprocal multiply.
    // The reciprocal error stays below one for any 30-bit value and count up to four.
    function automatic logic [BLOCK_W-1:0] seg_div(input logic [BLOCK_W-1:0] seg);
        logic [63:0] prod;
        prod = 64'(seg) * 64'(NDEV_RECIP);
        if (NDEV_POW2)
            seg_div = seg >> NDEV_LOG2;
        else
            seg_div = prod[32 +: BLOCK_W];
    endfunction

    function automatic logic [DEV_W-1:0] seg_mod(input logic [BLOCK_W-1:0] seg,
                                                 input logic [BLOCK_W-1:0] quo);
        logic [BLOCK_W-1:0] rem;
        rem = seg - BLOCK_W'(quo * BLOCK_W'(NUM_DEVICES));
        seg_mod = rem[DEV_W-1:0];
    endfunction

endpackage

[sv/ssbm_ifs.sv]
// Channel interfaces: mapping request, mapping result and register write.
interface ssbm_req_if
    import ssbm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BLOCK_W-1:0]   block_number;
    logic [BYTES_W-1:0]   byte_count;

    modport source (output valid, output block_number, output byte_count, input ready);
    modport sink   (input valid, input block_number, input byte_count, output ready);
endinterface

interface ssbm_rsp_if
    import ssbm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [DEV_W-1:0]      device_index;
    logic [SECTOR_W-1:0]   device_sector;

    modport source (output valid, output status, output device_index,
                    output device_sector, input ready);
    modport sink   (input valid, input status, input device_index,
                    input device_sector, output ready);
endinterface

interface ssbm_cfg_if
    import ssbm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/ssbm_cfg_regs.sv]
// Configuration register file for the stripe mapper.
module ssbm_cfg_regs
    import ssbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ssbm_cfg_if.sink    cfg,
    output cfg_t        cfg_out
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STRIPE_SHIFT:   regs_next.stripe_shift   = cfg.data[SHIFT_W-1:0];
                REG_DEV0_PAGES:     regs_next.dev_pages[0]   = cfg.data[DEVPG_W-1:0];
                REG_DEV1_PAGES:     regs_next.dev_pages[1]   = cfg.data[DEVPG_W-1:0];
                REG_DEV2_PAGES:     regs_next.dev_pages[2]   = cfg.data[DEVPG_W-1:0];
                REG_DEV3_PAGES:     regs_next.dev_pages[3]   = cfg.data[DEVPG_W-1:0];
                REG_DEVICE_PRESENT: regs_next.device_present = cfg.data[PRESENT_W-1:0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.stripe_shift   <= SHIFT_W'(4);
            regs_reg.dev_pages      <= '0;
            regs_reg.device_present <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

[sv/ssbm_map_logic.sv]
// Combinational stripe split, device select, bound checks and sector address.
module ssbm_map_logic
    import ssbm_pkg::*;
(
    input  cfg_t                 cfg,
    input  logic [BLOCK_W-1:0]   block_number,
    input  logic [BYTES_W-1:0]   byte_count,
    output result_t              result
);

    logic [BYTES_W:0]       bytes_sum;
    logic [PAGES_W-1:0]     pages;
    logic [31:0]            stripe_len;
    logic [31:0]            stripe_mask;
    logic [BLOCK_W-1:0]     offset;
    logic [BLOCK_W-1:0]     seg;
    logic [BLOCK_W-1:0]     seg_quo;
    logic [DEV_W-1:0]       dev;
    logic [BLOCK_W-1:0]     dev_block;
    logic                   crosses;
    logic [BLOCK_W:0]       end_page;
    logic [DEVPG_W-1:0]     dev_size;

    always_comb
    begin
        bytes_sum   = (BYTES_W+1)'(byte_count) + (BYTES_W+1)'((1 << PAGE_SHIFT) - 1);
        pages       = bytes_sum[BYTES_W:PAGE_SHIFT];
        stripe_len  = 32'd1 << cfg.stripe_shift;
        stripe_mask = stripe_len - 32'd1;
        offset      = block_number & stripe_mask[BLOCK_W-1:0];
        seg         = block_number >> cfg.stripe_shift;
        seg_quo     = seg_div(seg);

        crosses   = 1'b0;
        dev       = '0;
        dev_block = block_number;
        if (NUM_DEVICES > 1)
        begin
            crosses = ({1'b0, 32'(offset)} + 33'(pages)) > {1'b0, stripe_len};
            if (!crosses)
            begin
                dev       = seg_mod(seg, seg_quo);
                dev_block = (seg_quo << cfg.stripe_shift) + offset;
            end
        end

        dev_size = cfg.dev_pages[dev];
        end_page = (BLOCK_W+1)'(dev_block) + (BLOCK_W+1)'(pages);

        result.status        = STAT_OK;
        result.device_index  = dev;
        result.device_sector = '0;
        if (crosses)
        begin
            result.status = STAT_CROSS;
        end
        else if (end_page > (BLOCK_W+1)'(dev_size))
        begin
            result.status = STAT_END;
        end
        else if (!cfg.device_present[dev])
        begin
            result.status = STAT_ABSENT;
        end
        else
        begin
            result.device_sector = SECTOR_W'(dev_block) << SECTOR_SHIFT;
        end
    end

endmodule

[sv/striped_swap_block_mapper_unit.sv]
// Top level: request register, mapping logic, result register and config registers.
//
//  channel | modport | payload                                   | accepted when
//  req     | sink    | block_number[29:0], byte_count[23:0]      | valid && ready
//  rsp     | source  | status[1:0], device_index[1:0], sector    | valid && ready
//  cfg     | sink    | index[2:0], data[27:0]                    | valid (ready high)
//
// One request per cycle sustained while rsp.ready does not stall the result register.
// The request register feeds the mapping logic, which loads the result register.
// A stalled result holds both stages; req.ready drops only when both are full.
// Reset clears the stage valids and loads the register reset values.
module striped_swap_block_mapper_unit
    import ssbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ssbm_req_if.sink    req,
    ssbm_rsp_if.source  rsp,
    ssbm_cfg_if.sink    cfg
);

    cfg_t                 cfg_val;
    result_t              map_result;

    logic                 in_valid_reg;
    logic [BLOCK_W-1:0]   in_block_reg;
    logic [BYTES_W-1:0]   in_bytes_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    logic                 out_load;

    ssbm_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    ssbm_map_logic u_map_logic (
        .cfg          (cfg_val),
        .block_number (in_block_reg),
        .byte_count   (in_bytes_reg),
        .result       (map_result)
    );

    assign out_load  = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || out_load;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.device_index  = out_reg.device_index;
    assign rsp.device_sector = out_reg.device_sector;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_block_reg <= req.block_number;
            in_bytes_reg <= req.byte_count;
        end
        if (out_load && in_valid_reg)
            out_reg <= map_result;
    end

    // a stalled request stays in the input register
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_block_reg))
        else $error("request lost while result stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_load |=> rsp.valid)
        else $error("mapped request produced no result");

    a_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == STAT_CROSS |-> rsp.device_index == '0)
        else $error("stripe crossing with nonzero device");

    a_fail_no_sector: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STAT_OK |-> rsp.device_sector == '0)
        else $error("failed request carries a sector");

endmodule
